// ----- design/fts_pkg.sv -----
// Shared types and constants for the failover target selector.
`default_nettype none

package fts_pkg;

  localparam int MAX_TARGETS = 16;
  localparam int TIME_W      = 32;
  localparam int TIDX_W      = 4;
  localparam int NUM_W       = 5;
  localparam int SECS_W      = 16;
  localparam int CFG_IDX_W   = 2;

  localparam logic [1:0] FUNC_DISPATCH = 2'd0;
  localparam logic [1:0] FUNC_FAIL     = 2'd1;
  localparam logic [1:0] FUNC_TICK     = 2'd2;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_DISABLED = 2'd1;
  localparam logic [1:0] STATUS_RANGE    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_NUM_TARGETS     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DISABLE_SECONDS = 2'd1;

  typedef struct packed {
    logic [1:0]        func;
    logic [TIDX_W-1:0] target_index;
  } req_t;

  typedef struct packed {
    logic [TIDX_W-1:0] chosen_target;
    logic [1:0]        status;
    logic              reactivated_one;
    logic              reactivated_all;
  } rsp_t;

  // Command broadcast to every cell of the target chain.
  typedef struct packed {
    logic              apply;
    logic              dispatch;
    logic              fail;
    logic              none_found;
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] deadline;
  } cell_cmd_t;

endpackage

`default_nettype wire

// ----- design/fts_cell.sv -----
// One target entry: disabled flag, re-enable time and its link in the priority chain.
`default_nettype none

module fts_cell (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire fts_pkg::cell_cmd_t cmd,
  input  wire logic              in_use,
  input  wire logic              sel,
  input  wire logic              found_in,
  output logic                   found_out,
  output logic                   pick,
  output logic                   pick_timed,
  output logic                   disabled
);
  import fts_pkg::*;

  logic              disabled_next;
  logic [TIME_W-1:0] reenable_time;
  logic [TIME_W-1:0] reenable_time_next;
  logic              qual;

  // Register whether this entry may serve; the table is stable while an item is at work.
  always_ff @(posedge clk) begin
    qual <= !disabled || (cmd.now >= reenable_time);
  end

  assign pick       = in_use && qual && !found_in;
  assign found_out  = found_in || (in_use && qual);
  assign pick_timed = pick && disabled;

  always_comb begin
    disabled_next      = disabled;
    reenable_time_next = reenable_time;
    if (cmd.apply) begin
      if (cmd.dispatch) begin
        if (pick_timed || (cmd.none_found && in_use)) begin
          disabled_next = 1'b0;
        end
      end else if (cmd.fail && sel && in_use && !disabled) begin
        disabled_next      = 1'b1;
        reenable_time_next = cmd.deadline;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      disabled      <= 1'b0;
      reenable_time <= '0;
    end else begin
      disabled      <= disabled_next;
      reenable_time <= reenable_time_next;
    end
  end

endmodule

`default_nettype wire

// ----- design/failover_target_selector.sv -----
// A transaction is taken while idle; the registered per-cell qualify compare follows in the
//   evaluate state and the priority chain through the cells in the apply state, which is
//   held while a result waits in the output register and is stalled.
// The result waits in an output register, so a new transaction is taken while it is held.
// Reset (rst, synchronous): all targets enabled, re-enable times and seconds counter
//   zero, num_targets 1, disable_seconds 300.
`default_nettype none

module failover_target_selector (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           req_valid,
  output logic                                req_stall,
  input  wire fts_pkg::req_t                  req,
  output logic                                rsp_valid,
  input  wire logic                           rsp_stall,
  output fts_pkg::rsp_t                       rsp,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [fts_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [fts_pkg::SECS_W-1:0]     cfg_data
);
  import fts_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_EVAL  = 2'd1;
  localparam logic [1:0] ST_APPLY = 2'd2;
  localparam int         EXT_W    = 8;

  logic [1:0]        state;
  logic [1:0]        state_next;
  req_t              cur;
  logic [NUM_W-1:0]  num_targets;
  logic [SECS_W-1:0] disable_seconds;
  logic [TIME_W-1:0] now_seconds;
  logic [TIME_W-1:0] now_seconds_next;
  logic [TIME_W:0]   deadline_sum;
  logic              apply;

  logic [MAX_TARGETS-1:0] in_use;
  logic [MAX_TARGETS-1:0] sel;
  logic [MAX_TARGETS:0]   found;
  logic [MAX_TARGETS-1:0] pick;
  logic [MAX_TARGETS-1:0] pick_timed;
  logic [MAX_TARGETS-1:0] disabled;
  cell_cmd_t              cmd;
  rsp_t                   result;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_targets     <= NUM_W'(1);
      disable_seconds <= SECS_W'(300);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_NUM_TARGETS:     num_targets     <= cfg_data[NUM_W-1:0];
        REG_DISABLE_SECONDS: disable_seconds <= cfg_data;
        default: ;
      endcase
    end
  end

  assign req_stall = (state != ST_IDLE);
  assign apply     = (state == ST_APPLY) && (!rsp_valid || !rsp_stall);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (req_valid) state_next = ST_EVAL;
      ST_EVAL:  state_next = ST_APPLY;
      ST_APPLY: if (apply) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      cur <= req;
    end
  end

  // Entry zero is always in use; entries past the table are never in use.
  always_comb begin
    for (int i = 0; i < MAX_TARGETS; i++) begin
      in_use[i] = (i == 0) || ({{(EXT_W-NUM_W){1'b0}}, num_targets} > EXT_W'(i));
      sel[i]    = ({{(EXT_W-TIDX_W){1'b0}}, cur.target_index} == EXT_W'(i));
    end
  end

  assign deadline_sum = {1'b0, now_seconds} + {{(TIME_W-SECS_W+1){1'b0}}, disable_seconds};

  always_comb begin
    cmd.apply      = apply;
    cmd.dispatch   = (cur.func == FUNC_DISPATCH);
    cmd.fail       = (cur.func == FUNC_FAIL);
    cmd.none_found = !found[MAX_TARGETS];
    cmd.now        = now_seconds;
    cmd.deadline   = deadline_sum[TIME_W] ? {TIME_W{1'b1}} : deadline_sum[TIME_W-1:0];
  end

  assign found[0] = 1'b0;

  for (genvar g = 0; g < MAX_TARGETS; g++) begin : g_cell
    fts_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .cmd        (cmd),
      .in_use     (in_use[g]),
      .sel        (sel[g]),
      .found_in   (found[g]),
      .found_out  (found[g+1]),
      .pick       (pick[g]),
      .pick_timed (pick_timed[g]),
      .disabled   (disabled[g])
    );
  end

  always_comb begin
    result = '0;
    case (cur.func)
      FUNC_DISPATCH: begin
        for (int i = 0; i < MAX_TARGETS; i++) begin
          if (pick[i]) begin
            result.chosen_target = TIDX_W'(i);
          end
        end
        result.reactivated_one = |pick_timed;
        result.reactivated_all = !found[MAX_TARGETS];
      end
      FUNC_FAIL: begin
        if (!(|(sel & in_use))) begin
          result.status = STATUS_RANGE;
        end else if (|(sel & disabled)) begin
          result.status = STATUS_DISABLED;
        end else begin
          result.status = STATUS_OK;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    now_seconds_next = now_seconds;
    if (apply && (cur.func == FUNC_TICK) && (now_seconds != {TIME_W{1'b1}})) begin
      now_seconds_next = now_seconds + TIME_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      now_seconds <= '0;
    end else begin
      now_seconds <= now_seconds_next;
    end
  end

  // Hold the result until taken; load the next one when the slot frees.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (apply) begin
      rsp_valid <= 1'b1;
    end else if (rsp_valid && !rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (apply) begin
      rsp <= result;
    end
  end

  a_pick_onehot0: assert property (@(posedge clk) disable iff (rst)
    (state == ST_APPLY) |-> $onehot0(pick))
    else $error("more than one target picked");

  a_pick_found: assert property (@(posedge clk) disable iff (rst)
    (apply && cmd.dispatch && found[MAX_TARGETS]) |-> $onehot(pick))
    else $error("dispatch found a target but none picked");

  a_apply_delivers: assert property (@(posedge clk) disable iff (rst)
    apply |=> (rsp_valid && state == ST_IDLE))
    else $error("applied transaction did not reach the output");

  a_now_monotonic: assert property (@(posedge clk) disable iff (rst)
    (state != ST_APPLY) |=> (now_seconds == $past(now_seconds)))
    else $error("seconds counter moved outside an apply");

endmodule

`default_nettype wire
